// ===== src/tsfc_pkg.sv =====
// ----------------------------------------------------------------------------
// tsfc_pkg
// Shared constants, codes and controller/datapath interface types for the
// calibrated touch sample filter.
// ----------------------------------------------------------------------------
package tsfc_pkg;

  localparam int MAX_WINDOW = 8;
  localparam int IDX_W      = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CNT_W      = $clog2(MAX_WINDOW + 1);

  // window sums: MAX_WINDOW 16-bit values plus headroom
  localparam int SUM_W      = 17 + IDX_W;
  localparam int NUM_W      = SUM_W + 2;

  // accumulator of the affine map and dividend width of the divider
  localparam int ACC_W      = 50;
  localparam int DIV_W      = ACC_W;
  localparam int DIVR_W     = 18;
  localparam int IT_W       = $clog2(DIV_W + 1);
  localparam int AVG_ITERS  = NUM_W;
  localparam int MAP_ITERS  = DIV_W;

  localparam int CFG_IDX_W  = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_A = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_B = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_C = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_D = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_E = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_F = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_DIV_S  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_FSIZE  = 3'd7;

  typedef enum logic [1:0] {
    MUL_A,
    MUL_B,
    MUL_D,
    MUL_E
  } mul_sel_t;

  typedef enum logic [1:0] {
    DIV_AVGX,
    DIV_AVGY,
    DIV_MAPX,
    DIV_MAPY
  } div_sel_t;

  typedef struct packed {
    logic     capture;
    logic     walk_start;
    logic     scan_en;
    logic     sum_en;
    logic     div_start;
    div_sel_t div_sel;
    mul_sel_t mul_sel;
    logic     acc_load;
    logic     acc_y;
    logic     acc_add;
    logic     pass_load;
    logic     fin;
  } cmd_t;

  typedef struct packed {
    logic rep;
    logic release_evt;
    logic big;
    logic s_zero;
    logic walk_done;
    logic div_done;
  } stat_t;

  function automatic logic signed [15:0] sat16(input logic signed [DIV_W:0] v);
    logic signed [15:0] r;
    if (v > $signed((DIV_W+1)'(32767))) begin
      r = 16'sh7fff;
    end else if (v < -$signed((DIV_W+1)'(32768))) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

// ===== src/touch_sample_filter_calibrated.sv =====
// ----------------------------------------------------------------------------
// touch_sample_filter_calibrated
// Touch sample window filter with outlier rejection, rounded averaging and
// affine calibration of the reported position.
//
//   channel  | dir | transfer
//   in_*     | in  | one raw sample: x, y, button mask
//   out_*    | out | one result per sample: report fields and accepted flag
//   cfg_*    | in  | register write, one per cycle
//
// A sample that gives no report goes straight to the output register. A
// pressed report walks the window (N = window length) once for the outlier
// scan (skipped for N <= 2) and once for the sums through the ring read port,
// then the radix-2 divider runs four times. A release report skips the walk
// and the averaging divides. A zero divisor skips the map divides.
// Reset is synchronous; no clearing pass. A result waits in the output
// register while the next sample is already accepted and processed; a result
// still held there stalls the following one in its last cycle.
// ----------------------------------------------------------------------------
module touch_sample_filter_calibrated (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [39:0]                    in_tdata,   // raw_x, raw_y, buttons
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [39:0]                    out_tdata,  // report_valid, report_x,
                                                     // report_y, report_buttons,
                                                     // accepted
  input  logic                           cfg_we,
  input  logic [tsfc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_wdata
);

  tsfc_pkg::cmd_t  cmd;
  tsfc_pkg::stat_t st;

  tsfc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .st         (st),
    .cmd        (cmd)
  );

  tsfc_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .raw_x     (in_tdata[15:0]),
    .raw_y     (in_tdata[31:16]),
    .buttons   (in_tdata[36:32]),
    .cmd       (cmd),
    .st        (st),
    .out_data  (out_tdata)
  );

endmodule

// ===== src/tsfc_div.sv =====
// ----------------------------------------------------------------------------
// tsfc_div
// Radix-2 restoring divider, unsigned magnitudes, one quotient bit a cycle.
// The dividend arrives left aligned so that iters steps consume it.
// ----------------------------------------------------------------------------
module tsfc_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [tsfc_pkg::DIV_W-1:0]   dividend,
  input  logic [tsfc_pkg::DIVR_W-1:0]  divisor,
  input  logic [tsfc_pkg::IT_W-1:0]    iters,
  output logic [tsfc_pkg::DIV_W-1:0]   quo,
  output logic                         rem_nz,
  output logic                         done
);

  logic [tsfc_pkg::DIV_W-1:0]  q_r;
  logic [tsfc_pkg::DIVR_W-1:0] r_r;
  logic [tsfc_pkg::DIVR_W-1:0] d_r;
  logic [tsfc_pkg::IT_W-1:0]   cnt_r;
  logic                        busy_r;
  logic                        done_r;
  logic [tsfc_pkg::DIVR_W:0]   r_sh;
  logic                        ge;
  logic [tsfc_pkg::DIVR_W:0]   r_diff;

  assign r_sh   = {r_r, q_r[tsfc_pkg::DIV_W-1]};
  assign ge     = (r_sh >= {1'b0, d_r});
  assign r_diff = ge ? (r_sh - {1'b0, d_r}) : r_sh;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        q_r    <= dividend;
        r_r    <= '0;
        d_r    <= divisor;
        cnt_r  <= iters;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        q_r   <= {q_r[tsfc_pkg::DIV_W-2:0], ge};
        r_r   <= r_diff[tsfc_pkg::DIVR_W-1:0];
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == tsfc_pkg::IT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign quo    = q_r;
  assign rem_nz = |r_r;
  assign done   = done_r;

endmodule

// ===== src/tsfc_dp.sv =====
// ----------------------------------------------------------------------------
// tsfc_dp
// Datapath: configuration registers, sample ring, window walk (outlier scan
// and sums), shared divider, one multiplier, output register.
// ----------------------------------------------------------------------------
module tsfc_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [tsfc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [31:0]                       cfg_wdata,
  input  logic signed [15:0]                raw_x,
  input  logic signed [15:0]                raw_y,
  input  logic [4:0]                        buttons,
  input  tsfc_pkg::cmd_t                    cmd,
  output tsfc_pkg::stat_t                   st,
  output logic [39:0]                       out_data
);

  localparam int IW = tsfc_pkg::IDX_W;
  localparam int CW = tsfc_pkg::CNT_W;
  localparam int SW = tsfc_pkg::SUM_W;
  localparam int NW = tsfc_pkg::NUM_W;
  localparam int AW = tsfc_pkg::ACC_W;
  localparam int DW = tsfc_pkg::DIV_W;
  localparam int RW = tsfc_pkg::DIVR_W;

  logic signed [31:0] a_r, b_r, c_r, d_r, e_r, f_r;
  logic signed [17:0] s_r;
  logic [3:0]         fs_r;
  logic [CW-1:0]      win;

  logic [IW-1:0]      slot_r;
  logic [CW-1:0]      fill_r;
  logic [CW-1:0]      fill_nxt;
  logic [IW-1:0]      slot_nxt;
  logic signed [15:0] lx_r, ly_r;
  logic [31:0]        ring_m [tsfc_pkg::MAX_WINDOW];

  logic               rel_r, rep_r;
  logic [4:0]         btn_r;

  logic [CW-1:0]      idx_r;
  logic               pv_r;
  logic [IW-1:0]      pidx_r;
  logic [31:0]        rd_r;
  logic [17:0]        best_r;
  logic [IW-1:0]      skip_r;
  logic               skipv_r;
  logic signed [SW-1:0] sumx_r, sumy_r;
  logic [CW-1:0]      cnt_r;

  logic signed [15:0] avgx_r, avgy_r;
  logic signed [47:0] prod_r;
  logic signed [AW-1:0] acc_r;
  logic signed [15:0] resx_r, resy_r;

  tsfc_pkg::div_sel_t dsel_r;
  logic               dneg_r;

  logic               o_valid_r, o_acc_r;
  logic signed [15:0] o_x_r, o_y_r;
  logic [4:0]         o_btn_r;

  // window length clamp
  always_comb begin
    if (fs_r == 4'd0) begin
      win = CW'(1);
    end else if (int'(fs_r) > tsfc_pkg::MAX_WINDOW) begin
      win = CW'(tsfc_pkg::MAX_WINDOW);
    end else begin
      win = CW'(fs_r);
    end
  end

  assign fill_nxt = (fill_r < win) ? fill_r + 1'b1 : fill_r;
  assign slot_nxt = ((CW'(slot_r) + 1'b1) >= win) ? '0 : slot_r + 1'b1;

  // configuration and ring bookkeeping
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_r    <= 32'sd1;
      b_r    <= '0;
      c_r    <= '0;
      d_r    <= '0;
      e_r    <= 32'sd1;
      f_r    <= '0;
      s_r    <= 18'sd1;
      fs_r   <= 4'd5;
      slot_r <= '0;
      fill_r <= '0;
      lx_r   <= '0;
      ly_r   <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          tsfc_pkg::CFG_COEF_A: a_r <= cfg_wdata;
          tsfc_pkg::CFG_COEF_B: b_r <= cfg_wdata;
          tsfc_pkg::CFG_COEF_C: c_r <= cfg_wdata;
          tsfc_pkg::CFG_COEF_D: d_r <= cfg_wdata;
          tsfc_pkg::CFG_COEF_E: e_r <= cfg_wdata;
          tsfc_pkg::CFG_COEF_F: f_r <= cfg_wdata;
          tsfc_pkg::CFG_DIV_S:  s_r <= cfg_wdata[17:0];
          tsfc_pkg::CFG_FSIZE: begin
            fs_r   <= cfg_wdata[3:0];
            slot_r <= '0;
            fill_r <= '0;
          end
          default: ;
        endcase
      end else if (cmd.capture) begin
        if (buttons == 5'd0) begin
          slot_r <= '0;
          fill_r <= '0;
        end else begin
          slot_r <= slot_nxt;
          fill_r <= fill_nxt;
        end
      end
      if (cmd.fin && rep_r) begin
        lx_r <= resx_r;
        ly_r <= resy_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture && (buttons != 5'd0)) begin
      ring_m[slot_r] <= {raw_y, raw_x};
    end
    if ((cmd.scan_en || cmd.sum_en) && (idx_r < win)) begin
      rd_r <= ring_m[idx_r[IW-1:0]];
    end
  end

  // capture, window walk, outlier scan and sums
  logic signed [15:0] sx, sy;
  logic signed [16:0] dx, dy;
  logic [16:0]        adx, ady;
  logic [17:0]        mdist;

  assign sx    = rd_r[15:0];
  assign sy    = rd_r[31:16];
  assign dx    = {lx_r[15], lx_r} - {sx[15], sx};
  assign dy    = {ly_r[15], ly_r} - {sy[15], sy};
  assign adx   = dx[16] ? 17'(-dx) : 17'(dx);
  assign ady   = dy[16] ? 17'(-dy) : 17'(dy);
  assign mdist = {1'b0, adx} + {1'b0, ady};

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      btn_r   <= buttons;
      rel_r   <= (buttons == 5'd0);
      rep_r   <= (buttons == 5'd0) ? (fill_r >= win) : (fill_nxt >= win);
      best_r  <= '0;
      skipv_r <= 1'b0;
    end
    if (cmd.walk_start) begin
      idx_r  <= '0;
      pv_r   <= 1'b0;
      sumx_r <= '0;
      sumy_r <= '0;
      cnt_r  <= '0;
    end else if (cmd.scan_en || cmd.sum_en) begin
      if (idx_r < win) begin
        pidx_r <= idx_r[IW-1:0];
        idx_r  <= idx_r + 1'b1;
        pv_r   <= 1'b1;
      end else begin
        pv_r <= 1'b0;
      end
      if (pv_r && cmd.scan_en && (mdist > best_r)) begin
        best_r  <= mdist;
        skip_r  <= pidx_r;
        skipv_r <= 1'b1;
      end
      if (pv_r && cmd.sum_en && !(skipv_r && (pidx_r == skip_r))) begin
        sumx_r <= sumx_r + SW'(sx);
        sumy_r <= sumy_r + SW'(sy);
        cnt_r  <= cnt_r + 1'b1;
      end
    end
  end

  // divider operand selection
  logic signed [NW-1:0] num;
  logic [NW-1:0]        num_mag;
  logic [AW-1:0]        acc_mag;
  logic [RW-1:0]        s_mag;
  logic [DW-1:0]        dv_dividend;
  logic [RW-1:0]        dv_divisor;
  logic [tsfc_pkg::IT_W-1:0] dv_iters;
  logic                 dv_neg;
  logic [DW-1:0]        dv_quo;
  logic                 dv_rem_nz;
  logic                 dv_done;

  always_comb begin
    if (cmd.div_sel == tsfc_pkg::DIV_AVGX) begin
      num = (NW'(sumx_r) <<< 1) + NW'(cnt_r);
    end else begin
      num = (NW'(sumy_r) <<< 1) + NW'(cnt_r);
    end
    num_mag = num[NW-1] ? NW'(-num) : NW'(num);
    acc_mag = acc_r[AW-1] ? AW'(-acc_r) : AW'(acc_r);
    s_mag   = s_r[17] ? RW'(-s_r) : RW'(s_r);
    if ((cmd.div_sel == tsfc_pkg::DIV_AVGX) || (cmd.div_sel == tsfc_pkg::DIV_AVGY)) begin
      dv_dividend = DW'(num_mag) << (DW - tsfc_pkg::AVG_ITERS);
      dv_divisor  = RW'({cnt_r, 1'b0});
      dv_iters    = tsfc_pkg::IT_W'(tsfc_pkg::AVG_ITERS);
      dv_neg      = num[NW-1];
    end else begin
      dv_dividend = DW'(acc_mag);
      dv_divisor  = s_mag;
      dv_iters    = tsfc_pkg::IT_W'(tsfc_pkg::MAP_ITERS);
      dv_neg      = acc_r[AW-1] ^ s_r[17];
    end
  end

  tsfc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (dv_dividend),
    .divisor  (dv_divisor),
    .iters    (dv_iters),
    .quo      (dv_quo),
    .rem_nz   (dv_rem_nz),
    .done     (dv_done)
  );

  // signed quotient; averages round by floor of (2*sum+n)/(2n)
  logic signed [DW:0] q_m;
  logic signed [DW:0] q_s;
  logic signed [DW:0] q_fl;

  assign q_m  = $signed({1'b0, dv_quo});
  assign q_s  = dneg_r ? -q_m : q_m;
  assign q_fl = (dneg_r && dv_rem_nz) ? q_s - 1'b1 : q_s;

  // multiplier and accumulator
  logic signed [31:0] mcoef;
  logic signed [15:0] mop;

  always_comb begin
    case (cmd.mul_sel)
      tsfc_pkg::MUL_A: begin mcoef = a_r; mop = avgx_r; end
      tsfc_pkg::MUL_B: begin mcoef = b_r; mop = avgy_r; end
      tsfc_pkg::MUL_D: begin mcoef = d_r; mop = avgx_r; end
      tsfc_pkg::MUL_E: begin mcoef = e_r; mop = avgy_r; end
      default:         begin mcoef = a_r; mop = avgx_r; end
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= mcoef * mop;
    if (cmd.acc_load) begin
      acc_r <= AW'(cmd.acc_y ? f_r : c_r) + AW'(prod_r);
    end else if (cmd.acc_add) begin
      acc_r <= acc_r + AW'(prod_r);
    end
    if (cmd.div_start) begin
      dsel_r <= cmd.div_sel;
      dneg_r <= dv_neg;
    end
    if (cmd.capture) begin
      avgx_r <= raw_x;
      avgy_r <= raw_y;
    end
    if (dv_done) begin
      case (dsel_r)
        tsfc_pkg::DIV_AVGX: avgx_r <= q_fl[15:0];
        tsfc_pkg::DIV_AVGY: avgy_r <= q_fl[15:0];
        tsfc_pkg::DIV_MAPX: resx_r <= tsfc_pkg::sat16(q_s);
        tsfc_pkg::DIV_MAPY: resy_r <= tsfc_pkg::sat16(q_s);
        default: ;
      endcase
    end
    if (cmd.pass_load) begin
      resx_r <= avgx_r;
      resy_r <= avgy_r;
    end
    if (cmd.fin) begin
      o_valid_r <= rep_r;
      o_x_r     <= rep_r ? resx_r : '0;
      o_y_r     <= rep_r ? resy_r : '0;
      o_btn_r   <= rep_r ? btn_r : '0;
      o_acc_r   <= rel_r || rep_r;
    end
  end

  assign out_data = {1'b0, o_acc_r, o_btn_r, o_y_r, o_x_r, o_valid_r};

  assign st.rep         = rep_r;
  assign st.release_evt = rel_r;
  assign st.big         = (win > CW'(2));
  assign st.s_zero      = (s_r == '0);
  assign st.walk_done   = (idx_r == win) && !pv_r;
  assign st.div_done    = dv_done;

  a_slot_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    CW'(slot_r) < win) else $error("write slot outside window");

  a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= win) else $error("fill count above window length");

  a_walk_issued: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.scan_en || cmd.sum_en) && pv_r |-> idx_r != '0)
    else $error("ring data marked valid with no read issued");

endmodule

// ===== src/tsfc_ctrl.sv =====
// ----------------------------------------------------------------------------
// tsfc_ctrl
// Controller: sequences capture, outlier scan, sums, averaging divides,
// affine map and the output register handshake.
// ----------------------------------------------------------------------------
module tsfc_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  output logic            out_tvalid,
  input  logic            out_tready,
  input  tsfc_pkg::stat_t st,
  output tsfc_pkg::cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_IDLE, S_DEC, S_SCAN, S_SUM, S_AVGX, S_AVGY, S_MAP,
    S_MX1, S_MX2, S_MX3, S_DX, S_MY1, S_MY2, S_MY3, S_DY, S_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r;

  always_comb begin
    cmd         = '0;
    cmd.div_sel = tsfc_pkg::DIV_AVGX;
    cmd.mul_sel = tsfc_pkg::MUL_A;
    state_nxt   = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DEC;
        end
      end
      S_DEC: begin
        if (!st.rep) begin
          state_nxt = S_FIN;
        end else if (st.release_evt) begin
          state_nxt = S_MAP;
        end else begin
          cmd.walk_start = 1'b1;
          state_nxt      = st.big ? S_SCAN : S_SUM;
        end
      end
      S_SCAN: begin
        cmd.scan_en = 1'b1;
        if (st.walk_done) begin
          cmd.walk_start = 1'b1;
          state_nxt      = S_SUM;
        end
      end
      S_SUM: begin
        cmd.sum_en = 1'b1;
        if (st.walk_done) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = tsfc_pkg::DIV_AVGX;
          state_nxt     = S_AVGX;
        end
      end
      S_AVGX: begin
        cmd.div_sel = tsfc_pkg::DIV_AVGY;
        if (st.div_done) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_AVGY;
        end
      end
      S_AVGY: begin
        if (st.div_done) state_nxt = S_MAP;
      end
      S_MAP: begin
        if (st.s_zero) begin
          cmd.pass_load = 1'b1;
          state_nxt     = S_FIN;
        end else begin
          cmd.mul_sel = tsfc_pkg::MUL_A;
          state_nxt   = S_MX1;
        end
      end
      S_MX1: begin
        cmd.acc_load = 1'b1;
        cmd.mul_sel  = tsfc_pkg::MUL_B;
        state_nxt    = S_MX2;
      end
      S_MX2: begin
        cmd.acc_add = 1'b1;
        state_nxt   = S_MX3;
      end
      S_MX3: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = tsfc_pkg::DIV_MAPX;
        state_nxt     = S_DX;
      end
      S_DX: begin
        cmd.mul_sel = tsfc_pkg::MUL_D;
        if (st.div_done) state_nxt = S_MY1;
      end
      S_MY1: begin
        cmd.acc_load = 1'b1;
        cmd.acc_y    = 1'b1;
        cmd.mul_sel  = tsfc_pkg::MUL_E;
        state_nxt    = S_MY2;
      end
      S_MY2: begin
        cmd.acc_add = 1'b1;
        state_nxt   = S_MY3;
      end
      S_MY3: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = tsfc_pkg::DIV_MAPY;
        state_nxt     = S_DY;
      end
      S_DY: begin
        if (st.div_done) state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || out_tready) begin
          cmd.fin   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cmd.fin) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

endmodule
